// ===== rtl/core/ray_box_slab_intersect_macros.svh =====
// Assertion macros shared by the ray/box intersection RTL.
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RBSI_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RBSI_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rbsi_pkg.sv =====
// Types, widths and codes shared by the ray/box intersection block.
package rbsi_pkg;

  typedef logic signed [31:0] fx_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic               hit_flag;
    logic [30:0]        hit_dist;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [2:0]         face_code;
  } res_t;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LO_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LO_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LO_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HI_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HI_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HI_Z = 3'd5;

  localparam logic [2:0] FACE_NX = 3'd0;
  localparam logic [2:0] FACE_NY = 3'd1;
  localparam logic [2:0] FACE_NZ = 3'd2;
  localparam logic [2:0] FACE_PX = 3'd3;
  localparam logic [2:0] FACE_PY = 3'd4;
  localparam logic [2:0] FACE_PZ = 3'd5;

  localparam fx_t FX_ONE = 32'sd65536;
  localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
  localparam fx_t FX_MIN = 32'sh8000_0000;

  localparam logic [16:0] TEX_ONE = 17'h1_0000;

  // Slab divider: 33-bit magnitude << 16 over a 32-bit divisor, 32 quotient bits.
  localparam int SLAB_DW = 32;
  localparam int SLAB_QW = 32;
  // Texture divider: 33-bit numerator << 16 over a 33-bit extent, 16 quotient bits.
  localparam int TEX_DW = 33;
  localparam int TEX_QW = 16;

endpackage

// ===== rtl/core/rbsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rbsi_div #(
  parameter int DW = rbsi_pkg::SLAB_DW,
  parameter int QW = rbsi_pkg::SLAB_QW
) (
  input  logic          clk,
  input  logic [QW-1:0] ld,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [DW-1:0] div_in,
  output logic [QW-1:0] quo
);
  import rbsi_pkg::*;

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] div_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW-1:0] rem_s;
    logic [DW-1:0] div_s;
    logic [QW-1:0] low_s;
    logic [QW-1:0] q_s;
    logic [DW:0]   trial;
    logic          take;

    if (j == 0) begin : g_first
      assign rem_s = rem_in;
      assign div_s = div_in;
      assign low_s = low_in;
      assign q_s   = '0;
    end else begin : g_next
      assign rem_s = rem_r[j-1];
      assign div_s = div_r[j-1];
      assign low_s = low_r[j-1];
      assign q_s   = q_r[j-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {rem_s, low_s[QW-1]};
    assign take  = trial >= {1'b0, div_s};

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        rem_r[j] <= take ? DW'(trial - {1'b0, div_s}) : trial[DW-1:0];
        div_r[j] <= div_s;
        low_r[j] <= {low_s[QW-2:0], 1'b0};
        q_r[j]   <= {q_s[QW-2:0], take};
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ===== rtl/core/ray_box_slab_intersect.sv =====
// Ray against axis-aligned box: slab distances, hit point and face texture coordinates.
// Path: stages A, B, C, slab divider, R1 to R7, texture divider, output register.
// Throughput: one ray per cycle unless stalled; the 32-stage slab and 16-stage texture
// dividers are fully pipelined, and a stalled result holds only the stages behind it.
// Reset: valid bits clear, box registers return to the unit cube (lo 0, hi 1.0).
module ray_box_slab_intersect (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             ray_valid,
  output logic                             ray_stall,
  input  rbsi_pkg::ray_t                   ray,
  output logic                             res_valid,
  input  logic                             res_stall,
  output rbsi_pkg::res_t                   res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);
  import rbsi_pkg::*;

  localparam int ST_A    = 0;
  localparam int ST_B    = 1;
  localparam int ST_C    = 2;
  localparam int ST_SDIV = 3;
  localparam int ST_R1   = ST_SDIV + SLAB_QW;
  localparam int ST_R2   = ST_R1 + 1;
  localparam int ST_R3   = ST_R2 + 1;
  localparam int ST_R4   = ST_R3 + 1;
  localparam int ST_R5   = ST_R4 + 1;
  localparam int ST_R6   = ST_R5 + 1;
  localparam int ST_R7   = ST_R6 + 1;
  localparam int ST_TDIV = ST_R7 + 1;
  localparam int ST_OUT  = ST_TDIV + TEX_QW;
  localparam int NS      = ST_OUT + 1;

  typedef struct packed {
    fx_t [2:0]  o;
    fx_t [2:0]  d;
    logic [2:0] dz;
    logic [2:0] lopos;
    logic [2:0] hineg;
    logic [2:0] nsin;
    logic [2:0] nsout;
    logic [2:0] ovin;
    logic [2:0] ovout;
  } sside_t;

  typedef struct packed {
    logic       ok;
    fx_t        t;
    fx_t [2:0]  p;
    logic [2:0] face;
    logic       uzero;
    logic       uclamp;
    logic       vzero;
    logic       vclamp;
  } tside_t;

  // ---------------------------------------------------------------- config
  fx_t box_lo [3];
  fx_t box_hi [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= FX_ONE;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BOX_LO_X: box_lo[0] <= cfg_data;
        REG_BOX_LO_Y: box_lo[1] <= cfg_data;
        REG_BOX_LO_Z: box_lo[2] <= cfg_data;
        REG_BOX_HI_X: box_hi[0] <= cfg_data;
        REG_BOX_HI_Y: box_hi[1] <= cfg_data;
        REG_BOX_HI_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic [NS-1:0] vld;
  logic [NS-1:0] vld_next;
  logic [NS-1:0] free;

  // a stage takes new data when empty or when its item moves on
  assign free[NS-1] = !vld[NS-1] || !res_stall;
  for (genvar k = 0; k < NS - 1; k++) begin : g_free
    assign free[k] = !vld[k] || free[k+1];
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        vld_next[k] = free[k] ? ray_valid : vld[k];
      end else begin
        vld_next[k] = free[k] ? vld[k-1] : vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign ray_stall = !free[0];
  assign res_valid = vld[ST_OUT];

  // ---------------------------------------------------------------- stage A
  fx_t a_o [3];
  fx_t a_d [3];

  always_ff @(posedge clk) begin
    if (free[ST_A]) begin
      a_o[0] <= ray.origin_x;
      a_o[1] <= ray.origin_y;
      a_o[2] <= ray.origin_z;
      a_d[0] <= ray.dir_x;
      a_d[1] <= ray.dir_y;
      a_d[2] <= ray.dir_z;
    end
  end

  // ---------------------------------------------------------------- stage B
  logic signed [32:0] dlo [3];
  logic signed [32:0] dhi [3];

  fx_t                b_o [3];
  fx_t                b_d [3];
  logic signed [32:0] b_nin [3];
  logic signed [32:0] b_nout [3];
  logic [2:0]         b_dz;
  logic [2:0]         b_lopos;
  logic [2:0]         b_hineg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlo[i] = {box_lo[i][31], box_lo[i]} - {a_o[i][31], a_o[i]};
      dhi[i] = {box_hi[i][31], box_hi[i]} - {a_o[i][31], a_o[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (free[ST_B]) begin
      for (int i = 0; i < 3; i++) begin
        b_o[i]     <= a_o[i];
        b_d[i]     <= a_d[i];
        // near plane is lo unless the direction is negative
        b_nin[i]   <= a_d[i][31] ? dhi[i] : dlo[i];
        b_nout[i]  <= a_d[i][31] ? dlo[i] : dhi[i];
        b_dz[i]    <= a_d[i] == '0;
        b_lopos[i] <= dlo[i] > 33'sd0;
        b_hineg[i] <= dhi[i][32];
      end
    end
  end

  // ---------------------------------------------------------------- stage C
  fx_t         c_o [3];
  fx_t         c_d [3];
  logic [32:0] c_min [3];
  logic [32:0] c_mout [3];
  logic [31:0] c_dmag [3];
  logic [2:0]  c_nsin;
  logic [2:0]  c_nsout;
  logic [2:0]  c_dz;
  logic [2:0]  c_lopos;
  logic [2:0]  c_hineg;

  always_ff @(posedge clk) begin
    if (free[ST_C]) begin
      for (int i = 0; i < 3; i++) begin
        c_o[i]     <= b_o[i];
        c_d[i]     <= b_d[i];
        c_min[i]   <= b_nin[i][32] ? 33'(-b_nin[i]) : 33'(b_nin[i]);
        c_mout[i]  <= b_nout[i][32] ? 33'(-b_nout[i]) : 33'(b_nout[i]);
        c_dmag[i]  <= b_d[i][31] ? 32'(-b_d[i]) : 32'(b_d[i]);
        c_nsin[i]  <= b_nin[i][32] ^ b_d[i][31];
        c_nsout[i] <= b_nout[i][32] ^ b_d[i][31];
      end
      c_dz    <= b_dz;
      c_lopos <= b_lopos;
      c_hineg <= b_hineg;
    end
  end

  // ---------------------------------------------------------------- slab dividers
  logic [SLAB_QW-1:0] qin  [3];
  logic [SLAB_QW-1:0] qout [3];
  sside_t             ss_in;
  sside_t             ss [SLAB_QW];

  for (genvar i = 0; i < 3; i++) begin : g_slab
    rbsi_div #(
      .DW (SLAB_DW),
      .QW (SLAB_QW)
    ) u_div_in (
      .clk    (clk),
      .ld     (free[ST_SDIV +: SLAB_QW]),
      .rem_in (SLAB_DW'(c_min[i][32:16])),
      .low_in ({c_min[i][15:0], 16'h0000}),
      .div_in (c_dmag[i]),
      .quo    (qin[i])
    );

    rbsi_div #(
      .DW (SLAB_DW),
      .QW (SLAB_QW)
    ) u_div_out (
      .clk    (clk),
      .ld     (free[ST_SDIV +: SLAB_QW]),
      .rem_in (SLAB_DW'(c_mout[i][32:16])),
      .low_in ({c_mout[i][15:0], 16'h0000}),
      .div_in (c_dmag[i]),
      .quo    (qout[i])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ss_in.o[i] = c_o[i];
      ss_in.d[i] = c_d[i];
      // quotient of 2^32 or more saturates
      ss_in.ovin[i]  = SLAB_DW'(c_min[i][32:16]) >= c_dmag[i];
      ss_in.ovout[i] = SLAB_DW'(c_mout[i][32:16]) >= c_dmag[i];
    end
    ss_in.dz    = c_dz;
    ss_in.lopos = c_lopos;
    ss_in.hineg = c_hineg;
    ss_in.nsin  = c_nsin;
    ss_in.nsout = c_nsout;
  end

  for (genvar j = 0; j < SLAB_QW; j++) begin : g_sside
    always_ff @(posedge clk) begin
      if (free[ST_SDIV + j]) begin
        if (j == 0) begin
          ss[j] <= ss_in;
        end else begin
          ss[j] <= ss[j-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- R1: signed slab distances
  function automatic fx_t slab_val(input logic dz, input fx_t zval, input logic ov,
                                   input logic neg, input logic [SLAB_QW-1:0] q);
    fx_t r;
    if (dz) begin
      r = zval;
    end else if (ov || q[SLAB_QW-1]) begin
      r = neg ? FX_MIN : FX_MAX;
    end else begin
      r = neg ? -$signed(q) : $signed(q);
    end
    return r;
  endfunction

  sside_t sl;
  fx_t    r1_tin [3];
  fx_t    r1_tout [3];
  fx_t    r1_o [3];
  fx_t    r1_d [3];

  assign sl = ss[SLAB_QW-1];

  always_ff @(posedge clk) begin
    if (free[ST_R1]) begin
      for (int i = 0; i < 3; i++) begin
        r1_tin[i]  <= slab_val(sl.dz[i], sl.lopos[i] ? FX_MAX : FX_MIN, sl.ovin[i],
                               sl.nsin[i], qin[i]);
        r1_tout[i] <= slab_val(sl.dz[i], sl.hineg[i] ? FX_MIN : FX_MAX, sl.ovout[i],
                               sl.nsout[i], qout[i]);
        r1_o[i]    <= sl.o[i];
        r1_d[i]    <= sl.d[i];
      end
    end
  end

  // ---------------------------------------------------------------- R2: entry/exit reduction
  fx_t        t0_c;
  fx_t        t1_c;
  logic [2:0] face_c;

  always_comb begin
    // x wins over y only when strictly larger; z only when strictly larger
    if (r1_tin[0] > r1_tin[1]) begin
      t0_c   = r1_tin[0];
      face_c = r1_d[0][31] ? FACE_PX : FACE_NX;
    end else begin
      t0_c   = r1_tin[1];
      face_c = r1_d[1][31] ? FACE_PY : FACE_NY;
    end
    t1_c = (r1_tout[0] < r1_tout[1]) ? r1_tout[0] : r1_tout[1];
    if (r1_tin[2] > t0_c) begin
      t0_c   = r1_tin[2];
      face_c = r1_d[2][31] ? FACE_PZ : FACE_NZ;
    end
    if (r1_tout[2] < t1_c) begin
      t1_c = r1_tout[2];
    end
  end

  fx_t        r2_t0;
  fx_t        r2_t1;
  logic [2:0] r2_face;
  fx_t        r2_o [3];
  fx_t        r2_d [3];

  always_ff @(posedge clk) begin
    if (free[ST_R2]) begin
      r2_t0   <= t0_c;
      r2_t1   <= t1_c;
      r2_face <= face_c;
      r2_o    <= r1_o;
      r2_d    <= r1_d;
    end
  end

  // ---------------------------------------------------------------- R3: hit and facing test
  logic front_c;

  always_comb begin
    unique case (r2_face)
      FACE_NX: front_c = r2_d[0] > 32'sd0;
      FACE_NY: front_c = r2_d[1] > 32'sd0;
      FACE_NZ: front_c = r2_d[2] > 32'sd0;
      FACE_PX: front_c = r2_d[0][31];
      FACE_PY: front_c = r2_d[1][31];
      default: front_c = r2_d[2][31];
    endcase
  end

  logic       r3_ok;
  fx_t        r3_t;
  logic [2:0] r3_face;
  fx_t        r3_o [3];
  fx_t        r3_d [3];

  always_ff @(posedge clk) begin
    if (free[ST_R3]) begin
      r3_ok   <= (r2_t0 < r2_t1) && (r2_t1 > FX_ONE) && front_c;
      r3_t    <= (r2_t0 > FX_ONE) ? r2_t0 : r2_t1;
      r3_face <= r2_face;
      r3_o    <= r2_o;
      r3_d    <= r2_d;
    end
  end

  // ---------------------------------------------------------------- R4: direction times distance
  logic signed [63:0] r4_prod [3];
  logic               r4_ok;
  fx_t                r4_t;
  logic [2:0]         r4_face;
  fx_t                r4_o [3];

  always_ff @(posedge clk) begin
    if (free[ST_R4]) begin
      for (int i = 0; i < 3; i++) begin
        r4_prod[i] <= r3_d[i] * r3_t;
      end
      r4_ok   <= r3_ok;
      r4_t    <= r3_t;
      r4_face <= r3_face;
      r4_o    <= r3_o;
    end
  end

  // ---------------------------------------------------------------- R5: hit point
  logic signed [48:0] psum [3];
  fx_t                psat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // arithmetic shift rounds toward minus infinity
      psum[i] = {{17{r4_o[i][31]}}, r4_o[i]} + {r4_prod[i][63], r4_prod[i][63:16]};
      if (psum[i] > 49'sd2147483647) begin
        psat[i] = FX_MAX;
      end else if (psum[i] < -49'sd2147483648) begin
        psat[i] = FX_MIN;
      end else begin
        psat[i] = psum[i][31:0];
      end
    end
  end

  logic       r5_ok;
  fx_t        r5_t;
  logic [2:0] r5_face;
  fx_t        r5_p [3];

  always_ff @(posedge clk) begin
    if (free[ST_R5]) begin
      r5_ok   <= r4_ok;
      r5_t    <= r4_t;
      r5_face <= r4_face;
      r5_p    <= psat;
    end
  end

  // ---------------------------------------------------------------- R6: texture edge select
  fx_t edge_u;
  fx_t edge_v;
  fx_t pt_u;
  fx_t pt_v;
  logic [1:0] ax_u;
  logic [1:0] ax_v;

  always_comb begin
    unique case (r5_face)
      FACE_NX: begin
        edge_u = box_hi[2]; ax_u = 2'd2;
        edge_v = box_lo[1]; ax_v = 2'd1;
      end
      FACE_NY: begin
        edge_u = box_lo[0]; ax_u = 2'd0;
        edge_v = box_hi[2]; ax_v = 2'd2;
      end
      FACE_NZ: begin
        edge_u = box_lo[0]; ax_u = 2'd0;
        edge_v = box_lo[1]; ax_v = 2'd1;
      end
      FACE_PX: begin
        edge_u = box_lo[2]; ax_u = 2'd2;
        edge_v = box_lo[1]; ax_v = 2'd1;
      end
      FACE_PY: begin
        edge_u = box_lo[0]; ax_u = 2'd0;
        edge_v = box_lo[2]; ax_v = 2'd2;
      end
      default: begin
        edge_u = box_hi[0]; ax_u = 2'd0;
        edge_v = box_lo[1]; ax_v = 2'd1;
      end
    endcase
    pt_u = (ax_u == 2'd2) ? r5_p[2] : r5_p[0];
    pt_v = (ax_v == 2'd2) ? r5_p[2] : r5_p[1];
  end

  logic signed [32:0] r6_du;
  logic signed [32:0] r6_dv;
  logic signed [32:0] r6_eu;
  logic signed [32:0] r6_ev;
  logic               r6_ok;
  fx_t                r6_t;
  logic [2:0]         r6_face;
  fx_t                r6_p [3];

  always_ff @(posedge clk) begin
    if (free[ST_R6]) begin
      r6_du   <= {edge_u[31], edge_u} - {pt_u[31], pt_u};
      r6_dv   <= {edge_v[31], edge_v} - {pt_v[31], pt_v};
      r6_eu   <= (ax_u == 2'd2) ? {box_hi[2][31], box_hi[2]} - {box_lo[2][31], box_lo[2]}
                                : {box_hi[0][31], box_hi[0]} - {box_lo[0][31], box_lo[0]};
      r6_ev   <= (ax_v == 2'd2) ? {box_hi[2][31], box_hi[2]} - {box_lo[2][31], box_lo[2]}
                                : {box_hi[1][31], box_hi[1]} - {box_lo[1][31], box_lo[1]};
      r6_ok   <= r5_ok;
      r6_t    <= r5_t;
      r6_face <= r5_face;
      r6_p    <= r5_p;
    end
  end

  // ---------------------------------------------------------------- R7: magnitudes
  logic [32:0] r7_nu;
  logic [32:0] r7_nv;
  logic [32:0] r7_xu;
  logic [32:0] r7_xv;
  logic        r7_ok;
  fx_t         r7_t;
  logic [2:0]  r7_face;
  fx_t         r7_p [3];

  always_ff @(posedge clk) begin
    if (free[ST_R7]) begin
      r7_nu   <= r6_du[32] ? 33'(-r6_du) : 33'(r6_du);
      r7_nv   <= r6_dv[32] ? 33'(-r6_dv) : 33'(r6_dv);
      r7_xu   <= r6_eu[32] ? 33'(-r6_eu) : 33'(r6_eu);
      r7_xv   <= r6_ev[32] ? 33'(-r6_ev) : 33'(r6_ev);
      r7_ok   <= r6_ok;
      r7_t    <= r6_t;
      r7_face <= r6_face;
      r7_p    <= r6_p;
    end
  end

  // ---------------------------------------------------------------- texture dividers
  logic [TEX_QW-1:0] qu;
  logic [TEX_QW-1:0] qv;
  tside_t            ts_in;
  tside_t            ts [TEX_QW];

  rbsi_div #(
    .DW (TEX_DW),
    .QW (TEX_QW)
  ) u_div_u (
    .clk    (clk),
    .ld     (free[ST_TDIV +: TEX_QW]),
    .rem_in (r7_nu),
    .low_in ('0),
    .div_in (r7_xu),
    .quo    (qu)
  );

  rbsi_div #(
    .DW (TEX_DW),
    .QW (TEX_QW)
  ) u_div_v (
    .clk    (clk),
    .ld     (free[ST_TDIV +: TEX_QW]),
    .rem_in (r7_nv),
    .low_in ('0),
    .div_in (r7_xv),
    .quo    (qv)
  );

  always_comb begin
    ts_in.ok     = r7_ok;
    ts_in.t      = r7_t;
    ts_in.face   = r7_face;
    for (int i = 0; i < 3; i++) begin
      ts_in.p[i] = r7_p[i];
    end
    // numerator at or above the extent clamps to one, zero extent included
    ts_in.uzero  = r7_nu == '0;
    ts_in.uclamp = r7_nu >= r7_xu;
    ts_in.vzero  = r7_nv == '0;
    ts_in.vclamp = r7_nv >= r7_xv;
  end

  for (genvar j = 0; j < TEX_QW; j++) begin : g_tside
    always_ff @(posedge clk) begin
      if (free[ST_TDIV + j]) begin
        if (j == 0) begin
          ts[j] <= ts_in;
        end else begin
          ts[j] <= ts[j-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- output register
  tside_t tl;
  res_t   res_next;

  assign tl = ts[TEX_QW-1];

  always_comb begin
    res_next = '0;
    if (tl.ok) begin
      res_next.hit_flag  = 1'b1;
      res_next.hit_dist  = tl.t[30:0];
      res_next.point_x   = tl.p[0];
      res_next.point_y   = tl.p[1];
      res_next.point_z   = tl.p[2];
      res_next.tex_u     = tl.uzero ? '0 : (tl.uclamp ? TEX_ONE : {1'b0, qu});
      res_next.tex_v     = tl.vzero ? '0 : (tl.vclamp ? TEX_ONE : {1'b0, qv});
      res_next.face_code = tl.face;
    end
  end

  always_ff @(posedge clk) begin
    if (free[ST_OUT]) begin
      res <= res_next;
    end
  end

  // ---------------------------------------------------------------- assertions
  `include "ray_box_slab_intersect_macros.svh"

  `RBSI_NEXT(a_take_ray, ray_valid && !ray_stall, vld[ST_A], "accepted ray not captured")
  `RBSI_IMPLIES(a_miss_zero, res_valid && !res.hit_flag, res.hit_dist == '0 && res.face_code == '0 && res.tex_u == '0 && res.tex_v == '0, "miss result not cleared")
  `RBSI_IMPLIES(a_hit_range, res_valid && res.hit_flag, res.hit_dist > 31'd65536 && res.face_code <= FACE_PZ && res.tex_u <= TEX_ONE && res.tex_v <= TEX_ONE, "hit result out of range")

endmodule

// ===== bench/ray_box_slab_intersect_test.sv =====
// Self-checking bench for the ray/box slab intersection block.
`timescale 1ns / 100ps

module ray_box_slab_intersect_test;
  import rbsi_pkg::*;

  localparam int LATENCY     = 58;
  localparam int WDOG_LIMIT  = 20000;

  logic clk;
  logic rst;
  logic ray_valid;
  logic ray_stall;
  ray_t ray;
  logic res_valid;
  logic res_stall;
  res_t res;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  ray_box_slab_intersect u_top (
    .clk(clk), .rst(rst),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // box copy used for prediction
  longint box_lo[3];
  longint box_hi[3];

  res_t hit_queue[$];
  int   mismatches;
  int   idle_cycles;
  bit   timed_out;
  bit   hold_long;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor16(longint v);
    if (v >= 0) return v >>> 16;
    return -(((-v) + 65535) >>> 16);
  endfunction

  function automatic longint tex_frac(longint edge_v, longint p, longint extent);
    longint num;
    longint q;
    num = edge_v - p;
    if (num < 0) num = -num;
    if (num == 0) return 0;
    if (extent == 0) return 65536;
    q = (num * 65536) / extent;
    return (q > 65536) ? 65536 : q;
  endfunction

  function automatic res_t trace_ray(ray_t r);
    longint o[3], d[3], tin[3], tout[3], p[3], ext[3];
    longint dlo, dhi, t0, t1, t, u, v;
    logic [2:0] face;
    bit front;
    res_t y;
    o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
    d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
    y = '0;
    for (int i = 0; i < 3; i++) begin
      dlo = box_lo[i] - o[i];
      dhi = box_hi[i] - o[i];
      if (d[i] == 0) begin
        tin[i]  = (dlo > 0) ? 64'sd2147483647 : -64'sd2147483648;
        tout[i] = (dhi < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end else if (d[i] > 0) begin
        tin[i]  = sat32((dlo * 65536) / d[i]);
        tout[i] = sat32((dhi * 65536) / d[i]);
      end else begin
        tin[i]  = sat32((dhi * 65536) / d[i]);
        tout[i] = sat32((dlo * 65536) / d[i]);
      end
    end
    if (tin[0] > tin[1]) begin
      t0 = tin[0]; face = (d[0] >= 0) ? FACE_NX : FACE_PX;
    end else begin
      t0 = tin[1]; face = (d[1] >= 0) ? FACE_NY : FACE_PY;
    end
    t1 = (tout[0] < tout[1]) ? tout[0] : tout[1];
    if (tin[2] > t0) begin
      t0 = tin[2]; face = (d[2] >= 0) ? FACE_NZ : FACE_PZ;
    end
    if (tout[2] < t1) t1 = tout[2];
    if (!(t0 < t1 && t1 > 65536)) return y;
    t = (t0 > 65536) ? t0 : t1;
    case (face)
      FACE_NX: front = d[0] > 0;
      FACE_NY: front = d[1] > 0;
      FACE_NZ: front = d[2] > 0;
      FACE_PX: front = d[0] < 0;
      FACE_PY: front = d[1] < 0;
      default: front = d[2] < 0;
    endcase
    if (!front) return y;
    for (int i = 0; i < 3; i++) begin
      p[i] = sat32(o[i] + floor16(d[i] * t));
      ext[i] = box_hi[i] - box_lo[i];
      if (ext[i] < 0) ext[i] = -ext[i];
    end
    case (face)
      FACE_NX: begin
        u = tex_frac(box_hi[2], p[2], ext[2]); v = tex_frac(box_lo[1], p[1], ext[1]);
      end
      FACE_NY: begin
        u = tex_frac(box_lo[0], p[0], ext[0]); v = tex_frac(box_hi[2], p[2], ext[2]);
      end
      FACE_NZ: begin
        u = tex_frac(box_lo[0], p[0], ext[0]); v = tex_frac(box_lo[1], p[1], ext[1]);
      end
      FACE_PX: begin
        u = tex_frac(box_lo[2], p[2], ext[2]); v = tex_frac(box_lo[1], p[1], ext[1]);
      end
      FACE_PY: begin
        u = tex_frac(box_lo[0], p[0], ext[0]); v = tex_frac(box_lo[2], p[2], ext[2]);
      end
      default: begin
        u = tex_frac(box_hi[0], p[0], ext[0]); v = tex_frac(box_lo[1], p[1], ext[1]);
      end
    endcase
    y.hit_flag  = 1'b1;
    y.hit_dist  = t[30:0];
    y.point_x   = p[0][31:0];
    y.point_y   = p[1][31:0];
    y.point_z   = p[2][31:0];
    y.tex_u     = u[16:0];
    y.tex_v     = v[16:0];
    y.face_code = face;
    return y;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random Q16.16 value, mostly small, sometimes full range
  function automatic logic [31:0] rand_fx(int span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return 32'sd0;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // hold valid through the write; the caller drops it after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (idx < 3) box_lo[idx] = $signed(val);
    else if (idx < 6) box_hi[idx - 3] = $signed(val);
  endtask

  task automatic set_box(longint lx, longint ly, longint lz,
                         longint hx, longint hy, longint hz);
    write_reg(REG_BOX_LO_X, lx[31:0]);
    write_reg(REG_BOX_LO_Y, ly[31:0]);
    write_reg(REG_BOX_LO_Z, lz[31:0]);
    write_reg(REG_BOX_HI_X, hx[31:0]);
    write_reg(REG_BOX_HI_Y, hy[31:0]);
    write_reg(REG_BOX_HI_Z, hz[31:0]);
    cfg_valid <= 1'b0;
  endtask

  // offer one ray, hold it until accepted, queue its prediction
  task automatic send_ray(ray_t r, bit use_typed, res_t typed);
    int g;
    g = gap_len();
    if (g > 0) begin
      ray_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    ray_valid <= 1'b1;
    ray       <= r;
    do @(posedge clk); while (ray_stall);
    hit_queue.push_back(use_typed ? typed : trace_ray(r));
    @(negedge clk);
  endtask

  task automatic drain();
    ray_valid <= 1'b0;
    while (hit_queue.size() != 0 && !timed_out) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // receiver side: random stalls, one long hold-off
  initial begin
    res_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        res_stall <= 1'b1;
        repeat (200) @(negedge clk);
        hold_long = 1'b0;
      end
      if ($urandom_range(0, 99) < 3) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        res_stall <= ($urandom_range(0, 99) < 25);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (hit_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res);
      end else begin
        res_t e;
        e = hit_queue.pop_front();
        if (res !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, res);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (ray_valid && !ray_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  typedef struct {
    ray_t r;
    bit   typed;
    res_t y;
  } stim_row_t;

  localparam int FX1 = 65536;

  stim_row_t rows[$];

  function automatic ray_t mk(longint ox, longint oy, longint oz,
                               longint dx, longint dy, longint dz);
    ray_t r;
    r.origin_x = ox[31:0]; r.origin_y = oy[31:0]; r.origin_z = oz[31:0];
    r.dir_x = dx[31:0]; r.dir_y = dy[31:0]; r.dir_z = dz[31:0];
    return r;
  endfunction

  task automatic add_row(ray_t r, bit typed, res_t y);
    stim_row_t s;
    s.r = r; s.typed = typed; s.y = y;
    rows.push_back(s);
  endtask

  task automatic random_rays(int n, int span);
    ray_t r;
    for (int k = 0; k < n && !timed_out; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        // aim through the box from outside
        longint tx, ty, tz, ox, oy, oz;
        tx = box_lo[0] + (box_hi[0] - box_lo[0]) * longint'($urandom_range(0, 100)) / 100;
        ty = box_lo[1] + (box_hi[1] - box_lo[1]) * longint'($urandom_range(0, 100)) / 100;
        tz = box_lo[2] + (box_hi[2] - box_lo[2]) * longint'($urandom_range(0, 100)) / 100;
        ox = sat32(tx + $signed(rand_fx(span)) * 2);
        oy = sat32(ty + $signed(rand_fx(span)) * 2);
        oz = sat32(tz + $signed(rand_fx(span)) * 2);
        r = mk(ox, oy, oz, (tx - ox) / longint'($urandom_range(1, 4)),
               (ty - oy) / longint'($urandom_range(1, 4)),
               (tz - oz) / longint'($urandom_range(1, 4)));
      end else begin
        r = mk($signed(rand_fx(span)), $signed(rand_fx(span)), $signed(rand_fx(span)),
               $signed(rand_fx(span)), $signed(rand_fx(span)), $signed(rand_fx(span)));
      end
      send_ray(r, 1'b0, '0);
    end
  endtask

  initial begin
    res_t miss;
    miss = '0;
    rst = 1'b1;
    ray_valid = 1'b0;
    ray = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    timed_out = 1'b0;
    hold_long = 1'b0;
    box_lo = '{0, 0, 0};
    box_hi = '{FX1, FX1, FX1};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rays against the reset unit cube
    add_row(mk(0, 0, 0, 0, 0, 0), 1'b1, miss);                       // zero direction
    add_row(mk(-FX1, FX1/2, FX1/2, FX1, 0, 0), 1'b0, miss);          // -x face, zero y/z
    add_row(mk(FX1/2, -FX1, FX1/2, 0, FX1, 0), 1'b0, miss);          // -y face
    add_row(mk(FX1/2, FX1/2, -FX1, 0, 0, FX1), 1'b0, miss);          // -z face
    add_row(mk(3*FX1, FX1/2, FX1/2, -FX1, 0, 0), 1'b0, miss);        // +x face
    add_row(mk(FX1/2, 3*FX1, FX1/2, 0, -FX1, 0), 1'b0, miss);        // +y face
    add_row(mk(FX1/2, FX1/2, 3*FX1, 0, 0, -FX1), 1'b0, miss);        // +z face
    add_row(mk(-FX1, -FX1, FX1/2, FX1, FX1, 0), 1'b0, miss);         // x/y entry tie
    add_row(mk(-FX1, -FX1, -FX1, FX1, FX1, FX1), 1'b0, miss);        // triple tie
    add_row(mk(FX1/2, FX1/2, FX1/2, FX1, FX1, FX1), 1'b0, miss);     // origin inside
    add_row(mk(2*FX1, FX1/2, FX1/2, FX1, 0, 0), 1'b1, miss);         // moving away
    add_row(mk(-FX1/2, FX1/2, FX1/2, FX1, 0, 0), 1'b0, miss);        // entry 0.5, exit 1.5
    add_row(mk(0, FX1/2, FX1/2, FX1, 0, 0), 1'b0, miss);             // origin on plane
    add_row(mk(-FX1, 2*FX1, FX1/2, FX1, 0, 0), 1'b1, miss);          // outside y slab
    add_row(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 1'b0, miss);
    add_row(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 1'b0, miss);
    add_row(mk(-32768*FX1, FX1/2, FX1/2, 1, 0, 0), 1'b0, miss);      // saturated slab t
    add_row(mk(-FX1, FX1/2, FX1/2, 32'sh8000_0000, 1, -1), 1'b0, miss);
    add_row(mk(-5*FX1, -3*FX1, -4*FX1, 3*FX1, 2*FX1, 7*FX1/3), 1'b0, miss);
    foreach (rows[i]) send_ray(rows[i].r, rows[i].typed, rows[i].y);
    drain();

    // random phases across box settings, extremes among them
    random_rays(100, 4 * FX1);
    drain();
    set_box(-3*FX1, -2*FX1, -FX1, 5*FX1, 4*FX1, 6*FX1);
    write_reg(3'd7, 32'hDEAD_BEEF);                                  // unmapped index
    cfg_valid <= 1'b0;
    // long receiver hold while rays keep coming
    hold_long = 1'b1;
    random_rays(100, 8 * FX1);
    drain();
    set_box(FX1, FX1, FX1, FX1, 2*FX1, -FX1);                        // zero extent, swapped
    random_rays(60, 4 * FX1);
    drain();
    set_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    random_rays(70, 32'sh4000_0000);
    drain();
    set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_rays(40, 32'sh4000_0000);
    drain();
    set_box(-FX1/4, -FX1/4, -FX1/4, 3*FX1/4, 3*FX1/4, 3*FX1/4);
    random_rays(60, 2 * FX1);
    drain();

    if (mismatches == 0 && hit_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
